// ----- hw/rtl/fgn_pkg.sv -----
// Shared types, constants and arithmetic helpers for the fractal gradient noise block.
`timescale 1ns / 1ps
`default_nettype none
package fgn_pkg;
	localparam int TableSize = 256;
	localparam int TableBits = $clog2(TableSize);
	localparam int MaxOctaves = 8;
	localparam int OctBits = $clog2(MaxOctaves);
	localparam int FracBits = 16;
	localparam int CoordBits = 32;
	localparam int FreqBits = 32;
	localparam int CountBits = 4;
	localparam int OutBits = 19;
	localparam int ValBits = FracBits + 6;
	localparam int SumBits = FracBits + 6;
	localparam int ProdBits = CoordBits + FreqBits;
	localparam int CfgIdxBits = 1;
	localparam logic [FreqBits-1:0] FreqReset = 32'd21474836;
	localparam logic [CountBits-1:0] CountReset = 4'd8;
	localparam logic [CfgIdxBits-1:0] RegBaseFrequency = 1'b0;
	localparam logic [CfgIdxBits-1:0] RegOctaveCount = 1'b1;
	localparam logic KindLoad = 1'b0;

	typedef logic signed [ValBits-1:0] val_t;

	typedef struct packed {
		logic [0:0] kind;
		logic [7:0] table_index;
		logic [7:0] table_value;
		logic signed [CoordBits-1:0] coord_x;
		logic signed [CoordBits-1:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic signed [OutBits-1:0] noise_value;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCALE, ST_SETUP, ST_RD1, ST_RD2, ST_DOT, ST_FADE, ST_LERP, ST_ACC,
		ST_DONE
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic start;
		logic scale;
		logic setup;
		logic rd1;
		logic rd2;
		logic dot;
		logic fade;
		logic lerp;
		logic acc;
		logic [1:0] corner;
		logic [2:0] step;
		logic emit;
	} cmd_t;

	// floor(a * b / 2^FracBits) on signed operands.
	function automatic val_t qmul(input val_t a, input val_t b);
		logic signed [2*ValBits-1:0] p;
		p = a * b;
		return val_t'(p >>> FracBits);
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/fgn_stream_if.sv -----
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
`default_nettype none
interface fgn_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/fgn_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module fgn_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] addr,
	input wire logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/fgn_ctrl.sv -----
// Sequencer for loads, octaves, corner hashing and blending steps.
`timescale 1ns / 1ps
`default_nettype none
module fgn_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_kind,
	output logic in_ready,
	input wire logic out_ready,
	output logic out_valid,
	input wire logic [fgn_pkg::CountBits-1:0] octave_count,
	output fgn_pkg::cmd_t cmd
);
	import fgn_pkg::*;
	state_t state_q, state_next;
	logic [1:0] corner_q;
	logic [2:0] step_q;
	logic [OctBits-1:0] oct_q;
	logic [OctBits-1:0] last_oct;
	logic last_corner, last_step;

	always_comb begin
		if (octave_count == '0) begin
			last_oct = '0;
		end else if (octave_count > CountBits'(MaxOctaves)) begin
			last_oct = OctBits'(MaxOctaves - 1);
		end else begin
			last_oct = OctBits'(octave_count - 1'b1);
		end
	end
	assign last_corner = (corner_q == 2'd3);
	assign last_step = (step_q == 3'd4);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_kind != KindLoad) begin
					state_next = ST_SCALE;
				end
			end
			ST_SCALE: state_next = ST_SETUP;
			ST_SETUP: state_next = ST_RD1;
			ST_RD1: state_next = ST_RD2;
			ST_RD2: state_next = ST_DOT;
			ST_DOT: state_next = last_corner ? ST_FADE : ST_RD1;
			ST_FADE: state_next = last_step ? ST_LERP : ST_FADE;
			ST_LERP: state_next = (step_q == 3'd2) ? ST_ACC : ST_LERP;
			ST_ACC: state_next = (oct_q == last_oct) ? ST_DONE : ST_SETUP;
			ST_DONE: begin
				if (out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.corner = corner_q;
		cmd.step = step_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid && in_kind == KindLoad;
				cmd.start = in_valid && in_kind != KindLoad;
			end
			ST_SCALE: cmd.scale = 1'b1;
			ST_SETUP: cmd.setup = 1'b1;
			ST_RD1: cmd.rd1 = 1'b1;
			ST_RD2: cmd.rd2 = 1'b1;
			ST_DOT: cmd.dot = 1'b1;
			ST_FADE: cmd.fade = 1'b1;
			ST_LERP: cmd.lerp = 1'b1;
			ST_ACC: cmd.acc = 1'b1;
			ST_DONE: begin
				out_valid = 1'b1;
				cmd.emit = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			corner_q <= '0;
			step_q <= '0;
			oct_q <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_IDLE) begin
				oct_q <= '0;
			end else if (state_q == ST_ACC) begin
				oct_q <= oct_q + 1'b1;
			end
			if (state_q == ST_DOT) begin
				corner_q <= corner_q + 1'b1;
			end
			if ((state_q == ST_FADE && !last_step) ||
			    (state_q == ST_LERP && step_q != 3'd2)) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/fgn_dp.sv -----
// Datapath: coordinate scaling, table hashing, fade, interpolation and octave sum.
`timescale 1ns / 1ps
`default_nettype none
module fgn_dp (
	input wire logic clk,
	input wire logic arst_n,
	input fgn_pkg::cmd_t cmd,
	input fgn_pkg::in_item_t in_item,
	input wire logic [fgn_pkg::FreqBits-1:0] base_frequency,
	output fgn_pkg::out_item_t out_item
);
	import fgn_pkg::*;
	localparam int PBits = ProdBits + MaxOctaves;
	localparam val_t One = val_t'(1) <<< FracBits;

	logic signed [CoordBits-1:0] x_q, y_q;
	logic [ProdBits-1:0] px_q, py_q;
	logic signed [ProdBits:0] mx, my;
	logic [PBits-1:0] sx, sy;
	logic [TableBits-1:0] cx_q, cy_q;
	val_t xf_q, yf_q;
	logic [OctBits-1:0] oct_q;
	val_t dot_q [4];
	val_t u_q, v_q, acc_q;
	val_t l0_q, l1_q;
	logic signed [SumBits-1:0] sum_q;
	logic [TableBits-1:0] addr;
	logic [7:0] rdata;
	logic [TableBits-1:0] ccx, ccy;
	val_t dx, dy, g, fin, lin;
	logic signed [SumBits-1:0] sum_next;

	fgn_ram #(.Width(8), .Depth(TableSize)) u_perm (
		.clk(clk),
		.we(cmd.load),
		.addr(addr),
		.wdata(in_item.table_value),
		.rdata(rdata)
	);

	// Corner order: (0,0), (0,1), (1,0), (1,1) as x then y offsets.
	always_comb begin
		mx = $signed(x_q) * $signed({1'b0, base_frequency});
		my = $signed(y_q) * $signed({1'b0, base_frequency});
		sx = PBits'(px_q) << oct_q;
		sy = PBits'(py_q) << oct_q;
		ccx = cx_q + TableBits'(cmd.corner[1]);
		ccy = cy_q + TableBits'(cmd.corner[0]);
		dx = cmd.corner[1] ? xf_q - One : xf_q;
		dy = cmd.corner[0] ? yf_q - One : yf_q;
		if (cmd.load) begin
			addr = in_item.table_index[TableBits-1:0];
		end else if (cmd.rd2) begin
			addr = rdata[TableBits-1:0] + ccy;
		end else begin
			addr = ccx;
		end
		// The corner hash is on the read data in the cycle after the second read.
		case (rdata[1:0])
			2'd0: g = dx + dy;
			2'd1: g = dy - dx;
			2'd2: g = -dx - dy;
			default: g = dx - dy;
		endcase
		// Fade Horner steps for both axes share one step counter.
		case (cmd.step)
			3'd0: fin = val_t'(6) * xf_q - val_t'(15) * One;
			default: fin = '0;
		endcase
		lin = '0;
		sum_next = sum_q + SumBits'(acc_q >>> oct_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.start) begin
				oct_q <= '0;
				sum_q <= '0;
			end else if (cmd.acc) begin
				oct_q <= oct_q + 1'b1;
				sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= in_item.coord_x;
			y_q <= in_item.coord_y;
		end
		if (cmd.scale) begin
			px_q <= mx[ProdBits-1:0];
			py_q <= my[ProdBits-1:0];
		end
		if (cmd.setup) begin
			cx_q <= sx[48 +: TableBits];
			cy_q <= sy[48 +: TableBits];
			xf_q <= val_t'(sx[48-FracBits +: FracBits]);
			yf_q <= val_t'(sy[48-FracBits +: FracBits]);
		end
		if (cmd.dot) begin
			dot_q[cmd.corner] <= g;
		end
		if (cmd.fade) begin
			case (cmd.step)
				3'd0: begin
					u_q <= fin;
					v_q <= val_t'(6) * yf_q - val_t'(15) * One;
				end
				3'd1: begin
					u_q <= qmul(u_q, xf_q) + val_t'(10) * One;
					v_q <= qmul(v_q, yf_q) + val_t'(10) * One;
				end
				default: begin
					u_q <= qmul(u_q, xf_q);
					v_q <= qmul(v_q, yf_q);
				end
			endcase
		end
		if (cmd.lerp) begin
			case (cmd.step)
				3'd0: l0_q <= dot_q[0] + qmul(v_q, dot_q[1] - dot_q[0]);
				3'd1: l1_q <= dot_q[2] + qmul(v_q, dot_q[3] - dot_q[2]);
				default: acc_q <= l0_q + qmul(u_q, l1_q - l0_q) + lin;
			endcase
		end
	end

	always_comb begin
		if (sum_q > SumBits'(262143)) begin
			out_item.noise_value = OutBits'(262143);
		end else if (sum_q < -SumBits'(262144)) begin
			out_item.noise_value = OutBits'(-262144);
		end else begin
			out_item.noise_value = OutBits'(sum_q);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/fractal_gradient_noise_2d.sv -----
// Top level of the fractal 2D gradient noise block.
//
// Usage: items arrive on the in_ch channel and results leave on out_ch, both
// valid/ready. An input transaction with kind 0 writes one permutation table
// entry and produces no result; kind 1 samples the noise at (coord_x, coord_y).
// Software loads all table entries before sampling.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must keep
// to writing it while idle, which the block itself does not enforce. After a
// sample is accepted, a scaling step follows and then, per octave, a setup step,
// per corner two dependent reads of the single-port permutation RAM and the
// gradient dot, five fade steps, three interpolation steps and one accumulate.
// The result is then offered, and the next item is taken in the cycle after
// the result leaves. A load is written when it is accepted, and the input
// stays ready for the next item.
// One item is worked on at a time; the input is not ready while a sample is
// in progress or its result waits.
// When the receiver stalls the result is held in place until taken.
// Reset clears the control state and restores the register defaults; the
// permutation table is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module fractal_gradient_noise_2d (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [fgn_pkg::CfgIdxBits-1:0] cfg_index,
	input wire logic [fgn_pkg::FreqBits-1:0] cfg_data,
	fgn_stream_if.sink in_ch,
	fgn_stream_if.source out_ch
);
	import fgn_pkg::*;
	logic [FreqBits-1:0] base_frequency_q;
	logic [CountBits-1:0] octave_count_q;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_frequency_q <= FreqReset;
			octave_count_q <= CountReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegBaseFrequency: base_frequency_q <= cfg_data;
				RegOctaveCount: octave_count_q <= cfg_data[CountBits-1:0];
				default: ;
			endcase
		end
	end

	fgn_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_kind(in_ch.payload.kind[0]),
		.in_ready(in_ch.ready),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.octave_count(octave_count_q),
		.cmd(cmd)
	);

	fgn_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_item(in_ch.payload),
		.base_frequency(base_frequency_q),
		.out_item(out_ch.payload)
	);
endmodule
`default_nettype wire

// ----- dv/tb_fractal_gradient_noise_2d.sv -----
// Self-checking testbench for the fractal 2D gradient noise block.
`timescale 1ns / 1ps
module tb_fractal_gradient_noise_2d;
	import fgn_pkg::*;

	localparam int HoldCycles = 400;
	localparam int SettleCycles = 140;
	localparam int CycleLimit = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxBits-1:0] cfg_index = RegBaseFrequency;
	logic [FreqBits-1:0] cfg_data = '0;

	fgn_stream_if #(.payload_t(in_item_t)) in_ch();
	fgn_stream_if #(.payload_t(out_item_t)) out_ch();

	fractal_gradient_noise_2d i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Shadow state of the block.
	logic [7:0] perm_shadow [TableSize];
	logic [FreqBits-1:0] freq_shadow = FreqReset;
	logic [CountBits-1:0] count_shadow = CountReset;

	in_item_t pending_items [$];
	logic signed [OutBits-1:0] expected_noise [$];

	int errors = 0;
	int samples_checked = 0;
	int loads_sent = 0;
	int cycles = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic longint qmul_floor(longint a, longint b);
		return (a * b) >>> FracBits;
	endfunction

	function automatic longint fade_curve(longint t);
		longint r;
		r = 6 * t - 15 * (longint'(1) << FracBits);
		r = qmul_floor(r, t) + 10 * (longint'(1) << FracBits);
		r = qmul_floor(r, t);
		r = qmul_floor(r, t);
		return qmul_floor(r, t);
	endfunction

	function automatic longint corner_dot(logic [7:0] cx, logic [7:0] cy, longint dx, longint dy);
		logic [7:0] first;
		logic [7:0] h;
		first = perm_shadow[cx];
		h = perm_shadow[8'(first + cy)];
		case (h[1:0])
			2'd0: return dx + dy;
			2'd1: return -dx + dy;
			2'd2: return -dx - dy;
			default: return dx - dy;
		endcase
	endfunction

	function automatic longint blend(longint t, longint a, longint b);
		return a + qmul_floor(t, b - a);
	endfunction

	function automatic logic signed [OutBits-1:0] noise_predict(logic signed [31:0] x,
			logic signed [31:0] y);
		longint px, py, one, sum, xf, yf, bl, tl, br, tr, u, v;
		logic [7:0] cx, cy;
		int n;
		one = longint'(1) << FracBits;
		px = longint'(x) * longint'({32'b0, freq_shadow});
		py = longint'(y) * longint'({32'b0, freq_shadow});
		n = count_shadow;
		if (n < 1) n = 1;
		if (n > MaxOctaves) n = MaxOctaves;
		sum = 0;
		for (int o = 0; o < n; o++) begin
			cx = 8'(px >>> (48 - o));
			cy = 8'(py >>> (48 - o));
			xf = (px >>> (48 - o - FracBits)) & ((longint'(1) << FracBits) - 1);
			yf = (py >>> (48 - o - FracBits)) & ((longint'(1) << FracBits) - 1);
			bl = corner_dot(cx, cy, xf, yf);
			tl = corner_dot(cx, 8'(cy + 1), xf, yf - one);
			br = corner_dot(8'(cx + 1), cy, xf - one, yf);
			tr = corner_dot(8'(cx + 1), 8'(cy + 1), xf - one, yf - one);
			u = fade_curve(xf);
			v = fade_curve(yf);
			sum += blend(u, blend(v, bl, tl), blend(v, br, tr)) >>> o;
		end
		if (sum > 262143) sum = 262143;
		if (sum < -262144) sum = -262144;
		return OutBits'(sum);
	endfunction

	task automatic report_mismatch(input string what);
		$display("Mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	// Driver: the expectation is computed when the transaction is accepted.
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			if (in_ch.payload.kind == KindLoad) begin
				perm_shadow[in_ch.payload.table_index] = in_ch.payload.table_value;
				loads_sent++;
			end else begin
				expected_noise = {expected_noise, noise_predict(in_ch.payload.coord_x,
					in_ch.payload.coord_y)};
			end
		end
		if (!in_ch.valid || in_ch.ready) begin
			if (pending_items.size() > 0 && arst_n &&
					!(sender_idles && $urandom_range(99) < 26)) begin
				in_ch.valid <= 1'b1;
				in_ch.payload <= pending_items.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stalls.
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (expected_noise.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", out_ch.payload.noise_value));
			end else begin
				logic signed [OutBits-1:0] want;
				want = expected_noise.pop_front();
				if (out_ch.payload.noise_value !== want)
					report_mismatch($sformatf("noise_value %0d, expected %0d",
						out_ch.payload.noise_value, want));
				samples_checked++;
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HoldCycles;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= arst_n && !(receiver_idles && $urandom_range(99) < 26);
		end
	end

	task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [FreqBits-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegBaseFrequency) freq_shadow = val;
		else count_shadow = val[CountBits-1:0];
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_ch.valid || expected_noise.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic queue_sample(input logic [31:0] x, input logic [31:0] y);
		in_item_t it;
		it.kind = ~KindLoad;
		it.table_index = 8'($urandom);
		it.table_value = 8'($urandom);
		it.coord_x = x;
		it.coord_y = y;
		pending_items = {pending_items, it};
	endtask

	task automatic queue_load(input logic [7:0] idx, input logic [7:0] val);
		in_item_t it;
		it.kind = KindLoad;
		it.table_index = idx;
		it.table_value = val;
		it.coord_x = $urandom;
		it.coord_y = $urandom;
		pending_items = {pending_items, it};
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			2: return 32'($signed($urandom_range(131072)) - 65536);
			default: return $urandom & 32'h800FFFFF;
		endcase
	endfunction

	task automatic queue_random(input int count);
		repeat (count) begin
			if ($urandom_range(99) < 8) queue_load(8'($urandom), 8'($urandom));
			else queue_sample(random_coord(), random_coord());
		end
	endtask

	initial begin
		logic [7:0] shuffle [TableSize];
		logic [31:0] edges [6];
		logic [FreqBits-1:0] freqs [8];
		logic [CountBits-1:0] counts [8];
		logic [7:0] tmp;
		int j;

		edges = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h00010000, 32'h0000FFFF};
		freqs = '{32'hFFFFFFFF, 32'd1, 32'h80000000, $urandom, $urandom, 32'h01000000,
			$urandom, FreqReset};
		counts = '{4'd8, 4'd1, 4'd4, 4'd0, 4'd15, 4'd3, 4'($urandom_range(1, 8)), CountReset};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Load a full random permutation first; no entry is read before written.
		for (int i = 0; i < TableSize; i++) shuffle[i] = 8'(i);
		for (int i = TableSize - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = shuffle[i];
			shuffle[i] = shuffle[j];
			shuffle[j] = tmp;
		end
		for (int i = 0; i < TableSize; i++) queue_load(8'(i), shuffle[i]);

		// Directed corners of the coordinate range at the reset settings.
		foreach (edges[a]) queue_sample(edges[a], edges[(a + 1) % 6]);
		foreach (edges[a]) queue_sample(edges[a], edges[a]);
		queue_sample(32'h12345678, 32'hEDCBA988);
		wait_drained();

		foreach (freqs[p]) begin
			write_reg(RegBaseFrequency, freqs[p]);
			write_reg(RegOctaveCount, {28'b0, counts[p]});
			sender_idles = (p != 2);
			receiver_idles = (p != 2);
			if (p == 1) hold_req = 1'b1;
			if (p < 2) queue_sample(32'h7FFFFFFF, 32'h80000000);
			queue_random(100);
			if (p == 3) wait_drained();
			queue_random(100);
			wait_drained();
		end

		$display("Covered %0d samples checked and %0d table loads over %0d settings.",
			samples_checked, loads_sent, 9);
		$display("Included a long receiver stall, a sender pause and idle-free stretches.");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
hw/rtl/fgn_pkg.sv
hw/rtl/fgn_stream_if.sv
hw/rtl/fgn_ram.sv
hw/rtl/fgn_ctrl.sv
hw/rtl/fgn_dp.sv
hw/rtl/fractal_gradient_noise_2d.sv
dv/tb_fractal_gradient_noise_2d.sv
